>>> src/pla_pkg.sv
// ----------------------------------------------------------------------------
// pla_pkg: shared types and constants for the positional array list
// Word layouts of both channels, command and status codes, and the control
// bundle broadcast from the command decoder to the storage cells.
// ----------------------------------------------------------------------------
package pla_pkg;

  // field widths fixed by the word format
  localparam int CMD_W   = 3;
  localparam int IDX_W   = 4;
  localparam int DATA_W  = 32;
  localparam int CNT_W   = 5;
  localparam int STAT_W  = 2;
  // cell position width, covers the largest supported depth
  localparam int POS_W   = 8;

  localparam logic [CNT_W-1:0] CAP_RESET = CNT_W'(16);

  typedef enum logic [CMD_W-1:0] {
    CMD_GET       = 3'd0,
    CMD_SET       = 3'd1,
    CMD_INS_IDX   = 3'd2,
    CMD_REM_IDX   = 3'd3,
    CMD_INS_END   = 3'd4,
    CMD_REM_END   = 3'd5,
    CMD_INS_START = 3'd6,
    CMD_REM_START = 3'd7
  } cmd_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK        = 2'd0,
    ST_BAD_INDEX = 2'd1,
    ST_FULL      = 2'd2,
    ST_EMPTY     = 2'd3
  } status_t;

  // what every cell does this cycle
  typedef enum logic [1:0] {
    OP_HOLD = 2'd0,
    OP_SET  = 2'd1,
    OP_INS  = 2'd2,
    OP_REM  = 2'd3
  } cell_op_t;

  typedef struct packed {
    cell_op_t                  op;
    logic [CNT_W-1:0]          pos;
    logic [DATA_W-1:0]         value;
    logic                      rd_en;
    logic [CNT_W-1:0]          rd_pos;
  } cell_ctrl_t;

  typedef struct packed {
    logic [CMD_W-1:0]          cmd;
    logic [IDX_W-1:0]          index;
    logic signed [DATA_W-1:0]  value;
  } in_word_t;

  typedef struct packed {
    logic signed [DATA_W-1:0]  read_value;
    logic [STAT_W-1:0]         status;
    logic [CNT_W-1:0]          fill_count;
  } out_word_t;

endpackage

>>> src/pla_ctrl.sv
// ----------------------------------------------------------------------------
// pla_ctrl: command decoder
// Checks a command against the fill count and the limit, picks the status,
// the new fill count and the operation broadcast to the cell row.
// ----------------------------------------------------------------------------
module pla_ctrl (
  input  logic                       go,
  input  pla_pkg::in_word_t          word,
  input  logic [pla_pkg::CNT_W-1:0]  count,
  input  logic [pla_pkg::CNT_W-1:0]  limit,
  output pla_pkg::cell_ctrl_t        ctrl,
  output pla_pkg::status_t           status,
  output logic [pla_pkg::CNT_W-1:0]  count_next
);
  import pla_pkg::*;

  logic             full;
  logic             empty;
  logic [CNT_W-1:0] idx;
  cell_op_t         op;
  logic [CNT_W-1:0] pos;

  assign full  = (count >= limit);
  assign empty = (count == '0);
  assign idx   = CNT_W'(word.index);

  // status and cell operation per command
  always_comb begin
    status = ST_OK;
    op     = OP_HOLD;
    pos    = idx;
    case (cmd_t'(word.cmd))
      CMD_GET: begin
        if (idx >= count) status = ST_BAD_INDEX;
      end
      CMD_SET: begin
        if (idx >= count) status = ST_BAD_INDEX;
        else op = OP_SET;
      end
      CMD_INS_IDX: begin
        if (full) status = ST_FULL;
        else if (idx > count) status = ST_BAD_INDEX;
        else op = OP_INS;
      end
      CMD_REM_IDX: begin
        if (empty) status = ST_EMPTY;
        else if (idx >= count) status = ST_BAD_INDEX;
        else op = OP_REM;
      end
      CMD_INS_END: begin
        pos = count;
        if (full) status = ST_FULL;
        else op = OP_INS;
      end
      CMD_REM_END: begin
        pos = count - CNT_W'(1);
        if (empty) status = ST_EMPTY;
        else op = OP_REM;
      end
      CMD_INS_START: begin
        pos = '0;
        if (full) status = ST_FULL;
        else op = OP_INS;
      end
      CMD_REM_START: begin
        pos = '0;
        if (empty) status = ST_EMPTY;
        else op = OP_REM;
      end
      default: begin
        status = ST_OK;
        op     = OP_HOLD;
      end
    endcase
  end

  // fill count after the command
  always_comb begin
    case (op)
      OP_INS:  count_next = count + CNT_W'(1);
      OP_REM:  count_next = count - CNT_W'(1);
      default: count_next = count;
    endcase
  end

  // broadcast bundle, idle unless a word is taken
  assign ctrl.op     = go ? op : OP_HOLD;
  assign ctrl.pos    = pos;
  assign ctrl.value  = word.value;
  assign ctrl.rd_en  = (cmd_t'(word.cmd) == CMD_GET) && (status == ST_OK);
  assign ctrl.rd_pos = idx;

endmodule

>>> src/pla_cell.sv
// ----------------------------------------------------------------------------
// pla_cell: one list position
// Holds one entry; each cycle it holds, loads the command value, takes its
// lower neighbor (insert shift) or its upper neighbor (remove shift).
// ----------------------------------------------------------------------------
module pla_cell (
  input  logic                        clk,
  input  pla_pkg::cell_ctrl_t         ctrl,
  input  logic [pla_pkg::POS_W-1:0]   my_pos,
  input  logic [pla_pkg::DATA_W-1:0]  lower,
  input  logic [pla_pkg::DATA_W-1:0]  upper,
  output logic [pla_pkg::DATA_W-1:0]  data,
  output logic [pla_pkg::DATA_W-1:0]  rd_data
);
  import pla_pkg::*;

  logic [POS_W-1:0] pos;
  logic [POS_W-1:0] rd_pos;

  assign pos    = POS_W'(ctrl.pos);
  assign rd_pos = POS_W'(ctrl.rd_pos);

  // entry update
  always_ff @(posedge clk) begin
    case (ctrl.op)
      OP_SET: begin
        if (my_pos == pos) data <= ctrl.value;
      end
      OP_INS: begin
        if (my_pos == pos) data <= ctrl.value;
        else if (my_pos > pos) data <= lower;
      end
      OP_REM: begin
        if (my_pos >= pos) data <= upper;
      end
      default: begin
        data <= data;
      end
    endcase
  end

  // read tap, zero unless addressed
  assign rd_data = (ctrl.rd_en && (my_pos == rd_pos)) ? data : '0;

endmodule

>>> src/positional_array_list.sv
// ----------------------------------------------------------------------------
// positional_array_list: ordered list of signed 32-bit entries
// Row of DEPTH cells with a fill count; get, set, insert and remove by
// position, shifting the tail of the list in all cells at once.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel: cmd_valid / cmd_stall / cmd_word (cmd, index, value).
//   Result channel:  rsp_valid / rsp_stall / rsp_word (read_value, status,
//   fill_count). Every command gives exactly one result word.
//   Config: cfg_we / cfg_wdata write the capacity limit (0 acts as 1, values
//   above DEPTH act as DEPTH); write it only while the block is idle.
// Timing:
//   A command is decoded and applied to the cell row in the cycle it is
//   taken; its result is registered into rsp_word, or into the skid register
//   if an earlier one waits. One command per cycle unless cmd_stall is high.
//   When the receiver stalls, the result holds and one further result parks
//   in a skid register; cmd_stall rises only while that skid register is
//   occupied.
// Reset:
//   Synchronous, active high. Clears the fill count and both result valid
//   flags and sets the capacity register to 16. Entry contents are not cleared.
// ----------------------------------------------------------------------------
module positional_array_list #(
  parameter int DEPTH = 16
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cmd_valid,
  output logic                       cmd_stall,
  input  pla_pkg::in_word_t          cmd_word,
  output logic                       rsp_valid,
  input  logic                       rsp_stall,
  output pla_pkg::out_word_t         rsp_word,
  input  logic                       cfg_we,
  input  logic [pla_pkg::CNT_W-1:0]  cfg_wdata
);
  import pla_pkg::*;

  // largest limit: DEPTH, capped at the most the count field can express
  localparam int               LIM_MAX   = (DEPTH > 31) ? 31 : DEPTH;
  localparam logic [CNT_W-1:0] LIM_MAX_C = CNT_W'(LIM_MAX);

  logic [CNT_W-1:0]  capacity;
  logic [CNT_W-1:0]  limit;
  logic [CNT_W-1:0]  count;
  logic [CNT_W-1:0]  count_next;
  logic              accept;
  logic              take;
  cell_ctrl_t        ctrl;
  status_t           status;
  out_word_t         result;
  out_word_t         skid;
  logic              skid_valid;
  logic [DATA_W-1:0] cell_data [DEPTH];
  logic [DATA_W-1:0] cell_rd   [DEPTH];
  logic [DATA_W-1:0] rd_value;

  assign accept    = cmd_valid && !cmd_stall;
  assign take      = rsp_valid && !rsp_stall;
  assign cmd_stall = skid_valid;

  // capacity register and effective limit
  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CAP_RESET;
    end else if (cfg_we) begin
      capacity <= cfg_wdata;
    end
  end

  always_comb begin
    if (capacity == '0) limit = CNT_W'(1);
    else if (capacity > LIM_MAX_C) limit = LIM_MAX_C;
    else limit = capacity;
  end

  // command decode
  pla_ctrl u_ctrl (
    .go         (accept),
    .word       (cmd_word),
    .count      (count),
    .limit      (limit),
    .ctrl       (ctrl),
    .status     (status),
    .count_next (count_next)
  );

  // fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (accept) begin
      count <= count_next;
    end
  end

  // cell row, each cell sees its two neighbors
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [DATA_W-1:0] lower;
    logic [DATA_W-1:0] upper;
    if (i == 0) begin : g_lo_end
      assign lower = '0;
    end else begin : g_lo
      assign lower = cell_data[i-1];
    end
    if (i == DEPTH - 1) begin : g_up_end
      assign upper = '0;
    end else begin : g_up
      assign upper = cell_data[i+1];
    end
    pla_cell u_cell (
      .clk     (clk),
      .ctrl    (ctrl),
      .my_pos  (POS_W'(i)),
      .lower   (lower),
      .upper   (upper),
      .data    (cell_data[i]),
      .rd_data (cell_rd[i])
    );
  end

  // read data: at most one cell drives non-zero
  always_comb begin
    rd_value = '0;
    for (int i = 0; i < DEPTH; i++) begin
      rd_value = rd_value | cell_rd[i];
    end
  end

  assign result.read_value = rd_value;
  assign result.status     = status;
  assign result.fill_count = count_next;

  // result register plus skid stage
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (take) begin
        if (skid_valid) begin
          rsp_word   <= skid;
          skid_valid <= 1'b0;
        end else if (!accept) begin
          rsp_valid <= 1'b0;
        end
      end
      if (accept) begin
        if (!rsp_valid || take) begin
          rsp_word  <= result;
          rsp_valid <= 1'b1;
        end else begin
          skid       <= result;
          skid_valid <= 1'b1;
        end
      end
    end
  end

`ifndef SYNTH
  // fill count never passes the largest limit
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= LIM_MAX_C)
    else $error("fill count above limit");

  // skid word only exists behind a pending result
  a_skid_behind: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> rsp_valid)
    else $error("skid occupied without pending result");

  // a taken insert grows the list by one
  a_insert_count: assert property (@(posedge clk) disable iff (rst)
    (accept && ctrl.op == OP_INS) |=> (count == $past(count) + CNT_W'(1)))
    else $error("insert did not advance fill count");

  // a taken remove shrinks the list by one
  a_remove_count: assert property (@(posedge clk) disable iff (rst)
    (accept && ctrl.op == OP_REM) |=> (count == $past(count) - CNT_W'(1)))
    else $error("remove did not reduce fill count");
`endif

endmodule

>>> tb/pla_list_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// pla_list_checker: result predictor and comparator for the array list
// Watches the command, result and config ports, keeps its own copy of the
// list contents, fill count and capacity limit, and checks each result word
// against the oldest expected word.
// ----------------------------------------------------------------------------
module pla_list_checker #(
  parameter int DEPTH = 16
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cmd_valid,
  input  logic                      cmd_stall,
  input  pla_pkg::in_word_t         cmd_word,
  input  logic                      rsp_valid,
  input  logic                      rsp_stall,
  input  pla_pkg::out_word_t        rsp_word,
  input  logic                      cfg_we,
  input  logic [pla_pkg::CNT_W-1:0] cfg_wdata,
  output int                        mismatches,
  output int                        pending,
  output int                        compared
);
  import pla_pkg::*;

  // shadow list state
  logic [DATA_W-1:0] list_vals [DEPTH];
  int                list_len;
  logic [CNT_W-1:0]  cap_reg;

  // results predicted but not yet seen
  out_word_t         expected_words [$];
  int                bad_words;
  int                good_words;

  // limit in force: zero acts as one, anything past the depth as the depth
  function automatic int cap_now();
    int lim;
    lim = int'(cap_reg);
    if (lim < 1) lim = 1;
    if (lim > DEPTH) lim = DEPTH;
    return lim;
  endfunction

  // full check comes before the index check
  function automatic status_t list_insert(input int pos, input logic [DATA_W-1:0] v);
    if (list_len >= cap_now()) return ST_FULL;
    if (pos > list_len) return ST_BAD_INDEX;
    for (int i = list_len; i > pos; i--) list_vals[i] = list_vals[i-1];
    list_vals[pos] = v;
    list_len++;
    return ST_OK;
  endfunction

  // empty check first, so remove-end on an empty list reports empty
  function automatic status_t list_remove(input int pos);
    if (list_len == 0) return ST_EMPTY;
    if (pos < 0 || pos >= list_len) return ST_BAD_INDEX;
    for (int i = pos; i + 1 < list_len; i++) list_vals[i] = list_vals[i+1];
    list_len--;
    return ST_OK;
  endfunction

  // apply one command to the shadow list, return the word it should produce
  function automatic out_word_t list_step(input in_word_t w);
    out_word_t r;
    int        idx;
    r = '0;
    idx = int'(w.index);
    r.status = ST_OK;
    case (cmd_t'(w.cmd))
      CMD_GET: begin
        if (idx < list_len) r.read_value = list_vals[idx];
        else r.status = ST_BAD_INDEX;
      end
      CMD_SET: begin
        if (idx < list_len) list_vals[idx] = w.value;
        else r.status = ST_BAD_INDEX;
      end
      CMD_INS_IDX:   r.status = list_insert(idx, w.value);
      CMD_REM_IDX:   r.status = list_remove(idx);
      CMD_INS_END:   r.status = list_insert(list_len, w.value);
      CMD_REM_END:   r.status = list_remove(list_len - 1);
      CMD_INS_START: r.status = list_insert(0, w.value);
      CMD_REM_START: r.status = list_remove(0);
      default:       r.status = ST_OK;
    endcase
    r.fill_count = CNT_W'(list_len);
    return r;
  endfunction

  // track config, compare results, predict new commands
  always @(posedge clk) begin : track
    out_word_t want;
    if (rst) begin
      list_len = 0;
      cap_reg = CAP_RESET;
      expected_words.delete();
      bad_words = 0;
      good_words = 0;
    end else begin
      if (cfg_we) cap_reg = cfg_wdata;
      if (rsp_valid && !rsp_stall) begin
        if (expected_words.size() == 0) begin
          bad_words++;
          if (bad_words <= 10)
            $display("%0t: unexpected result word rd=%0d st=%0d fill=%0d", $time,
                     rsp_word.read_value, rsp_word.status, rsp_word.fill_count);
        end else begin
          want = expected_words.pop_front();
          good_words++;
          if (rsp_word.read_value !== want.read_value || rsp_word.status !== want.status ||
              rsp_word.fill_count !== want.fill_count) begin
            bad_words++;
            if (bad_words <= 10)
              $display({"%0t: result mismatch exp rd=%0d st=%0d fill=%0d,",
                        " got rd=%0d st=%0d fill=%0d"},
                       $time, want.read_value, want.status, want.fill_count,
                       rsp_word.read_value, rsp_word.status, rsp_word.fill_count);
          end
        end
      end
      if (cmd_valid && !cmd_stall) expected_words.push_back(list_step(cmd_word));
    end
    mismatches <= bad_words;
    pending    <= expected_words.size();
    compared   <= good_words;
  end

endmodule

>>> tb/tb_positional_array_list.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_positional_array_list: regression for the positional array list
// Directed corner commands on an empty, partly filled and full list, then
// about a thousand random commands in phases, each with its own capacity
// limit and mix of sender gaps and receiver stalls; a separate checker
// predicts and compares every result word.
// ----------------------------------------------------------------------------
module tb_positional_array_list;
  import pla_pkg::*;

  localparam int LIST_DEPTH  = 16;
  localparam int QUIET_LIMIT = 3000;
  localparam int HOLD_CYCLES = 300;
  localparam int PHASE_ITEMS = 100;
  localparam int NUM_PHASES  = 10;

  logic             clk       = 1'b0;
  logic             rst       = 1'b1;
  logic             cmd_valid = 1'b0;
  logic             cmd_stall;
  in_word_t         cmd_word  = '0;
  logic             rsp_valid;
  logic             rsp_stall = 1'b0;
  out_word_t        rsp_word;
  logic             cfg_we    = 1'b0;
  logic [CNT_W-1:0] cfg_wdata = '0;

  int   mismatches;
  int   pending;
  int   compared;

  // traffic shaping
  int   idle_pct  = 0;
  int   stall_pct = 0;
  logic hold_req  = 1'b0;
  logic hold_seen = 1'b0;
  int   hold_left = 0;
  int   quiet     = 0;
  int   cur_cap   = 16;
  int   sent      = 0;
  int   op_hits [8];

  // limit per random phase: 0 and 31 exercise the clamp, 3 after 16 cuts
  // the limit below a filled list
  int   phase_caps [NUM_PHASES] = '{16, 0, 31, 5, 16, 3, 1, 17, 2, 9};

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  positional_array_list #(.DEPTH(LIST_DEPTH)) DUT (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .cmd_word  (cmd_word),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp_word  (rsp_word),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  pla_list_checker #(.DEPTH(LIST_DEPTH)) u_checker (
    .clk        (clk),
    .rst        (rst),
    .cmd_valid  (cmd_valid),
    .cmd_stall  (cmd_stall),
    .cmd_word   (cmd_word),
    .rsp_valid  (rsp_valid),
    .rsp_stall  (rsp_stall),
    .rsp_word   (rsp_word),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .mismatches (mismatches),
    .pending    (pending),
    .compared   (compared)
  );

  // result side: random stalls, or a long hold-off when requested
  always @(posedge clk) begin
    if (hold_left > 0) begin
      rsp_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_req != hold_seen) begin
      hold_seen <= hold_req;
      hold_left <= HOLD_CYCLES;
      rsp_stall <= 1'b1;
    end else begin
      rsp_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // watchdog: too long without any word moving on either port
  always @(posedge clk) begin
    if (rst || (cmd_valid && !cmd_stall) || (rsp_valid && !rsp_stall)) begin
      quiet <= 0;
    end else if (quiet >= QUIET_LIMIT) begin
      $display("watchdog: no traffic for %0d cycles", QUIET_LIMIT);
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  function automatic in_word_t mk(input cmd_t c, input int idx, input logic [DATA_W-1:0] v);
    in_word_t w;
    w.cmd   = c;
    w.index = IDX_W'(idx);
    w.value = v;
    return w;
  endfunction

  // random command; grow bursts favor inserts, shrink bursts removes
  function automatic in_word_t random_word(input bit grow);
    int                roll;
    int                span;
    int                idx;
    cmd_t              c;
    logic [DATA_W-1:0] v;
    roll = $urandom_range(99);
    if (roll < 12) c = CMD_GET;
    else if (roll < 22) c = CMD_SET;
    else if (roll < (grow ? 80 : 45)) begin
      case ($urandom_range(2))
        0:       c = CMD_INS_IDX;
        1:       c = CMD_INS_END;
        default: c = CMD_INS_START;
      endcase
    end else begin
      case ($urandom_range(2))
        0:       c = CMD_REM_IDX;
        1:       c = CMD_REM_END;
        default: c = CMD_REM_START;
      endcase
    end
    // indices mostly within reach of the current limit
    span = (cur_cap < 1) ? 1 : (cur_cap > LIST_DEPTH - 1) ? LIST_DEPTH - 1 : cur_cap;
    idx = ($urandom_range(9) < 8) ? $urandom_range(span) : $urandom_range(LIST_DEPTH - 1);
    case ($urandom_range(7))
      0:       v = 32'h8000_0000;
      1:       v = 32'h7FFF_FFFF;
      2:       v = '1;
      default: v = $urandom();
    endcase
    return mk(c, idx, v);
  endfunction

  // offer one word, with random gaps, and wait until it is taken
  task automatic send_word(input in_word_t w);
    while ($urandom_range(99) < idle_pct) begin
      cmd_valid <= 1'b0;
      @(posedge clk);
    end
    cmd_valid <= 1'b1;
    cmd_word  <= w;
    @(posedge clk);
    while (cmd_stall) @(posedge clk);
    sent++;
    op_hits[w.cmd]++;
  endtask

  // stop offering and wait until every result has come back
  task automatic settle();
    cmd_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_limit(input int lim);
    settle();
    cfg_we    <= 1'b1;
    cfg_wdata <= CNT_W'(lim);
    @(posedge clk);
    cfg_we    <= 1'b0;
    cur_cap = lim;
  endtask

  initial begin : stimulus
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // empty list: every access is a bad index, every remove reports empty
    send_word(mk(CMD_GET, 0, 0));
    send_word(mk(CMD_SET, 0, 1));
    send_word(mk(CMD_REM_END, 0, 0));
    send_word(mk(CMD_REM_START, 0, 0));
    send_word(mk(CMD_REM_IDX, 0, 0));
    send_word(mk(CMD_INS_IDX, 1, 5));
    // build a short list with extreme values, last one appended by index
    send_word(mk(CMD_INS_IDX, 0, 32'h7FFF_FFFF));
    send_word(mk(CMD_INS_END, 0, 32'h8000_0000));
    send_word(mk(CMD_INS_START, 15, 32'hFFFF_FFFF));
    send_word(mk(CMD_INS_IDX, 3, 32'h0000_0000));
    send_word(mk(CMD_SET, 3, 32'h1234_5678));
    for (int i = 0; i < 5; i++) send_word(mk(CMD_GET, i, 32'hA5A5_A5A5));
    send_word(mk(CMD_REM_IDX, 4, 0));
    send_word(mk(CMD_REM_IDX, 1, 0));
    send_word(mk(CMD_REM_END, 9, 0));
    send_word(mk(CMD_REM_START, 0, 0));
    send_word(mk(CMD_GET, 15, 0));

    // zero limit acts as one: the single remaining entry already fills it
    write_limit(0);
    send_word(mk(CMD_INS_END, 0, 32'h0000_0055));
    send_word(mk(CMD_INS_IDX, 9, 32'h0000_0066));
    send_word(mk(CMD_REM_START, 0, 0));
    send_word(mk(CMD_INS_START, 0, 32'hDEAD_BEEF));
    send_word(mk(CMD_GET, 0, 0));

    // random phases, cycling through the idle and stall mixes
    for (int p = 0; p < NUM_PHASES; p++) begin
      write_limit(phase_caps[p]);
      case (p % 4)
        0: begin idle_pct = 0;  stall_pct <= 0;  end
        1: begin idle_pct = 85; stall_pct <= 0;  end
        2: begin idle_pct = 0;  stall_pct <= 85; end
        default: begin idle_pct = 26; stall_pct <= 26; end
      endcase
      // back-to-back commands against a long receiver hold fill the skid
      if (p == 4) hold_req <= ~hold_req;
      for (int k = 0; k < PHASE_ITEMS; k++) send_word(random_word(((k / 25) % 2) == 0));
    end

    idle_pct = 0;
    stall_pct <= 0;
    settle();

    $display("Covered %0d commands: get %0d, set %0d, ins@ %0d, rem@ %0d, ins_end %0d,",
             sent, op_hits[CMD_GET], op_hits[CMD_SET], op_hits[CMD_INS_IDX],
             op_hits[CMD_REM_IDX], op_hits[CMD_INS_END]);
    $display("rem_end %0d, ins_start %0d, rem_start %0d; %0d results checked over %0d limits",
             op_hits[CMD_REM_END], op_hits[CMD_INS_START], op_hits[CMD_REM_START],
             compared, NUM_PHASES + 1);
    if (mismatches == 0 && pending == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
